>>> src/smpc_pkg.sv
// smpc_pkg: shared types, constants and reset values for the segment mesh
// pixel coverage block. No dependencies.
package smpc_pkg;

    localparam int MAX_POINTS_DEF = 64;
    localparam int CW             = 18;   // coordinate width, 4 fraction bits
    localparam int COLW           = 32;   // packed RGBA8

    // action codes
    localparam logic ACT_LOAD  = 1'b0;
    localparam logic ACT_PIXEL = 1'b1;

    // link modes
    localparam logic [2:0] LINK_ALL     = 3'd0;
    localparam logic [2:0] LINK_EVEN    = 3'd1;
    localparam logic [2:0] LINK_THIRD   = 3'd2;
    localparam logic [2:0] LINK_QUARTER = 3'd3;
    localparam logic [2:0] LINK_RING    = 3'd4;

    // config register indexes
    localparam logic [2:0] CFG_POINT_COUNT = 3'd0;
    localparam logic [2:0] CFG_LINK_MODE   = 3'd1;
    localparam logic [2:0] CFG_LINK_STEP   = 3'd2;
    localparam logic [2:0] CFG_HALF_THICK  = 3'd3;
    localparam logic [2:0] CFG_TILE_PITCH  = 3'd4;
    localparam logic [2:0] CFG_LINE_COLOR  = 3'd5;
    localparam logic [2:0] CFG_BG_COLOR    = 3'd6;
    localparam logic [2:0] CFG_BG_ENABLED  = 3'd7;

    // reset values
    localparam logic [6:0]      RST_POINT_COUNT = 7'd12;
    localparam logic [2:0]      RST_LINK_MODE   = LINK_ALL;
    localparam logic [5:0]      RST_LINK_STEP   = 6'd1;
    localparam logic [6:0]      RST_HALF_THICK  = 7'd40;
    localparam logic [16:0]     RST_TILE_PITCH  = 17'd0;
    localparam logic [COLW-1:0] RST_LINE_COLOR  = 32'hFFFF_FFFF;
    localparam logic [COLW-1:0] RST_BG_COLOR    = 32'd9764863;
    localparam logic            RST_BG_ENABLED  = 1'b1;

    typedef struct packed {
        logic                 action;
        logic [5:0]           vertex_index;
        logic signed [CW-1:0] coord_x;
        logic signed [CW-1:0] coord_y;
        logic                 last_in_region;
    } t_item;

    typedef struct packed {
        logic [6:0]      point_count;
        logic [2:0]      link_mode;
        logic [5:0]      link_step;
        logic [6:0]      half_width;
        logic [16:0]     tile_pitch;
        logic [COLW-1:0] line_color;
        logic [COLW-1:0] background_color;
        logic            background_enabled;
    } t_cfg;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MOD,
        ST_RUN,
        ST_DRAIN
    } t_state;

endpackage

>>> src/smpc_ifs.sv
// smpc_ifs: valid/ready channel interfaces for input items, result items
// and configuration writes. Depends on smpc_pkg.
interface smpc_in_if;
    import smpc_pkg::*;
    logic                 valid;
    logic                 ready;
    logic                 action;
    logic [5:0]           vertex_index;
    logic signed [CW-1:0] coord_x;
    logic signed [CW-1:0] coord_y;
    logic                 last_in_region;
    modport source (output valid, action, vertex_index, coord_x, coord_y,
                    last_in_region, input ready);
    modport sink   (input valid, action, vertex_index, coord_x, coord_y,
                    last_in_region, output ready);
endinterface

interface smpc_out_if;
    import smpc_pkg::*;
    logic            valid;
    logic            ready;
    logic [COLW-1:0] pixel_color;
    logic            covered;
    logic            end_of_region;
    modport source (output valid, pixel_color, covered, end_of_region, input ready);
    modport sink   (input valid, pixel_color, covered, end_of_region, output ready);
endinterface

interface smpc_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [31:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

>>> src/smpc_ram.sv
// smpc_ram: generic RAM, one write port, two registered read ports.
// No dependencies.
module smpc_ram #(
    parameter int WIDTH = 36,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_a,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic [WIDTH-1:0]         o_rdata_a,
    output logic [WIDTH-1:0]         o_rdata_b
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata_a <= r_mem[i_raddr_a];
        o_rdata_b <= r_mem[i_raddr_b];
    end
endmodule

>>> src/smpc_front.sv
// smpc_front: accepts input items, drops loads beyond the table and queues
// the rest in a two-entry FIFO. Depends on smpc_pkg and smpc_ifs.
module smpc_front
    import smpc_pkg::*;
#(
    parameter int MAX_POINTS = MAX_POINTS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    smpc_in_if.sink     i_in,
    output t_item       o_item,
    output logic        o_item_valid,
    input  logic        i_item_ready
);
    t_item      r_fifo [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_count;
    logic       w_keep;
    logic       w_push;
    logic       w_pop;
    t_item      w_item;

    assign i_in.ready = (r_count != 2'd2);

    // loads outside the table are swallowed here
    assign w_keep = (i_in.action == ACT_PIXEL) || (int'(i_in.vertex_index) < MAX_POINTS);
    assign w_push = i_in.valid && i_in.ready && w_keep;
    assign w_pop  = o_item_valid && i_item_ready;

    assign w_item.action         = i_in.action;
    assign w_item.vertex_index   = i_in.vertex_index;
    assign w_item.coord_x        = i_in.coord_x;
    assign w_item.coord_y        = i_in.coord_y;
    assign w_item.last_in_region = i_in.last_in_region;

    assign o_item       = r_fifo[r_rp];
    assign o_item_valid = (r_count != 2'd0);

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_fifo[r_wp] <= w_item;
        end
        if (!i_rst_n) begin
            r_wp    <= 1'b0;
            r_rp    <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (w_push) r_wp <= ~r_wp;
            if (w_pop)  r_rp <= ~r_rp;
            r_count <= r_count + 2'(w_push) - 2'(w_pop);
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= 2'd2)
        else $error("front queue overfilled");
endmodule

>>> src/smpc_back.sv
// smpc_back: vertex table, pair sequencer and pipelined segment test.
// Depends on smpc_pkg, smpc_ifs and smpc_ram.
module smpc_back
    import smpc_pkg::*;
#(
    parameter int MAX_POINTS = MAX_POINTS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_item       i_item,
    input  logic        i_item_valid,
    output logic        o_item_ready,
    input  t_cfg        i_cfg,
    smpc_out_if.source  o_out
);
    localparam int AW = $clog2(MAX_POINTS);
    localparam int NW = $clog2(MAX_POINTS + 1);

    t_state r_state, n_state;
    logic signed [CW-1:0] r_px, n_px, r_py, n_py;
    logic        r_last, n_last;
    logic [NW-1:0] r_n, n_n, r_q, n_q, r_mq, n_mq;
    logic [5:0]  r_s, n_s;
    logic [13:0] r_h2, n_h2;
    logic        r_tiled, n_tiled;
    logic [1:0]  r_tx, n_tx, r_ty, n_ty, r_m3, n_m3;
    logic [AW-1:0] r_j, n_j, r_k, n_k;
    logic        r_hit;
    logic        r_ov;
    logic [COLW-1:0] r_color;
    logic        r_cov, r_eor;

    logic [NW-1:0] w_nsat, w_qraw, w_q;
    logic [AW-1:0] w_d;
    logic        w_linked, w_last_k, w_last_j, w_last_tile;
    logic        w_start, w_load, w_emit;
    logic signed [CW-1:0] w_tile, w_offx, w_offy;
    logic [2*CW-1:0] w_rd_a, w_rd_b;

    // front side handshake and first-time setup values
    assign o_item_ready = (r_state == ST_IDLE);
    assign w_start = i_item_valid && o_item_ready && (i_item.action == ACT_PIXEL);
    assign w_load  = i_item_valid && o_item_ready && (i_item.action == ACT_LOAD);
    assign w_nsat  = (i_cfg.point_count > 7'(MAX_POINTS)) ? NW'(MAX_POINTS)
                                                         : NW'(i_cfg.point_count);
    assign w_qraw  = w_nsat >> 2;
    assign w_q     = (w_qraw == '0) ? NW'(1) : w_qraw;

    // link test for the current pair
    assign w_d = r_k - r_j;
    always_comb begin
        case (i_cfg.link_mode)
            LINK_ALL:     w_linked = 1'b1;
            LINK_EVEN:    w_linked = !w_d[0];
            LINK_THIRD:   w_linked = (r_m3 == 2'd0);
            LINK_QUARTER: w_linked = (r_mq == '0);
            LINK_RING:    w_linked = (r_s != 6'd0) && ((7'(w_d) == 7'(r_s)) ||
                                     (7'(w_d) == 7'(r_n) - 7'(r_s)));
            default:      w_linked = 1'b0;
        endcase
    end

    assign w_last_k    = (NW'(r_k) == r_n - NW'(1));
    assign w_last_j    = (NW'(r_j) == r_n - NW'(2));
    assign w_last_tile = !r_tiled || ((r_tx == 2'd2) && (r_ty == 2'd2));

    assign w_tile = signed'({1'b0, i_cfg.tile_pitch});
    assign w_offx = (r_tx == 2'd0) ? -w_tile : ((r_tx == 2'd2) ? w_tile : '0);
    assign w_offy = (r_ty == 2'd0) ? -w_tile : ((r_ty == 2'd2) ? w_tile : '0);

    // pipeline stage valids, declared ahead of the sequencer that checks them
    logic r_v1, r_v2, r_v3, r_v4, r_v5;
    logic w_busy;
    assign w_busy = r_v1 || r_v2 || r_v3 || r_v4 || r_v5;
    assign w_emit = (r_state == ST_DRAIN) && !w_busy && (!r_ov || o_out.ready);

    // sequencer
    always_comb begin
        n_state = r_state;
        n_px = r_px;  n_py = r_py;  n_last = r_last;
        n_n = r_n;  n_q = r_q;  n_s = r_s;  n_h2 = r_h2;  n_tiled = r_tiled;
        n_tx = r_tx;  n_ty = r_ty;  n_j = r_j;  n_k = r_k;
        n_m3 = r_m3;  n_mq = r_mq;
        case (r_state)
            ST_IDLE: begin
                if (w_start) begin
                    n_px = i_item.coord_x;
                    n_py = i_item.coord_y;
                    n_last = i_item.last_in_region;
                    n_n = w_nsat;
                    n_q = w_q;
                    n_s = i_cfg.link_step;
                    n_h2 = 14'(i_cfg.half_width) * 14'(i_cfg.half_width);
                    n_tiled = (i_cfg.tile_pitch != '0);
                    n_tx = (i_cfg.tile_pitch != '0) ? 2'd0 : 2'd1;
                    n_ty = (i_cfg.tile_pitch != '0) ? 2'd0 : 2'd1;
                    n_j = '0;
                    n_k = AW'(1);
                    n_m3 = 2'd1;
                    n_mq = (w_q == NW'(1)) ? '0 : NW'(1);
                    if (w_nsat < NW'(2)) begin
                        n_state = ST_DRAIN;
                    end else if (i_cfg.link_mode == LINK_RING) begin
                        n_state = ST_MOD;
                    end else begin
                        n_state = ST_RUN;
                    end
                end
            end
            ST_MOD: begin
                // ring step reduced modulo the point count, one subtract a cycle
                if (7'(r_s) >= 7'(r_n)) begin
                    n_s = r_s - 6'(r_n);
                end else begin
                    n_state = ST_RUN;
                end
            end
            ST_RUN: begin
                if (!w_last_k) begin
                    n_k = r_k + AW'(1);
                    n_m3 = (r_m3 == 2'd2) ? 2'd0 : r_m3 + 2'd1;
                    n_mq = (r_mq == r_q - NW'(1)) ? '0 : r_mq + NW'(1);
                end else begin
                    n_m3 = 2'd1;
                    n_mq = (r_q == NW'(1)) ? '0 : NW'(1);
                    if (!w_last_j) begin
                        n_j = r_j + AW'(1);
                        n_k = r_j + AW'(2);
                    end else begin
                        n_j = '0;
                        n_k = AW'(1);
                        if (w_last_tile) begin
                            n_state = ST_DRAIN;
                        end else if (r_ty == 2'd2) begin
                            n_tx = r_tx + 2'd1;
                            n_ty = 2'd0;
                        end else begin
                            n_ty = r_ty + 2'd1;
                        end
                    end
                end
            end
            ST_DRAIN: begin
                if (w_emit) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= ST_IDLE;
        else          r_state <= n_state;
        r_px <= n_px;  r_py <= n_py;  r_last <= n_last;
        r_n <= n_n;  r_q <= n_q;  r_s <= n_s;  r_h2 <= n_h2;  r_tiled <= n_tiled;
        r_tx <= n_tx;  r_ty <= n_ty;  r_j <= n_j;  r_k <= n_k;
        r_m3 <= n_m3;  r_mq <= n_mq;
    end

    // vertex table: x in the upper half, y in the lower
    smpc_ram #(
        .WIDTH (2 * CW),
        .DEPTH (MAX_POINTS)
    ) u_ram (
        .i_clk     (i_clk),
        .i_we      (w_load),
        .i_waddr   (i_item.vertex_index[AW-1:0]),
        .i_wdata   ({i_item.coord_x, i_item.coord_y}),
        .i_raddr_a (r_j),
        .i_raddr_b (r_k),
        .o_rdata_a (w_rd_a),
        .o_rdata_b (w_rd_b)
    );

    // stage 1: table data arrives with the tile offsets
    logic signed [CW-1:0] r_offx1, r_offy1;
    logic signed [CW-1:0] w_xj, w_yj, w_xk, w_yk;
    logic signed [CW:0]   w_sx, w_sy;
    assign w_xj = signed'(w_rd_a[2*CW-1:CW]);
    assign w_yj = signed'(w_rd_a[CW-1:0]);
    assign w_xk = signed'(w_rd_b[2*CW-1:CW]);
    assign w_yk = signed'(w_rd_b[CW-1:0]);
    assign w_sx = (CW+1)'(w_xj) + (CW+1)'(r_offx1);
    assign w_sy = (CW+1)'(w_yj) + (CW+1)'(r_offy1);

    // stage 2: differences
    logic signed [CW+1:0] r_ax, r_ay;
    logic signed [CW:0]   r_dx, r_dy;
    logic signed [CW+2:0] r_ex, r_ey;
    logic signed [CW+1:0] w_ax, w_ay;
    logic signed [CW:0]   w_dx, w_dy;
    assign w_ax = (CW+2)'(r_px) - (CW+2)'(w_sx);
    assign w_ay = (CW+2)'(r_py) - (CW+2)'(w_sy);
    assign w_dx = (CW+1)'(w_xk) - (CW+1)'(w_xj);
    assign w_dy = (CW+1)'(w_yk) - (CW+1)'(w_yj);

    // stage 3: products
    logic signed [41:0] r_pd1, r_pd2, r_pl1, r_pl2, r_pa1, r_pa2;
    logic signed [41:0] r_pe1, r_pe2, r_pc1, r_pc2;

    // stage 4: sums
    logic signed [43:0] r_dot, r_len2, r_da2, r_de2, r_cross;

    // stage 5: case split and the two wide products
    logic signed [43:0] w_h2s, w_c;
    logic [37:0] w_len2u;
    logic [25:0] w_c26;
    logic        w_zero, w_near, w_far, w_big, w_simple, w_need;
    logic        r_simple, r_need;
    logic [51:0] r_cc, r_hl;
    assign w_h2s    = 44'(r_h2);
    assign w_c      = (r_cross < 0) ? -r_cross : r_cross;
    assign w_c26    = w_c[25:0];
    assign w_len2u  = r_len2[37:0];
    assign w_zero   = (r_len2 == '0);
    assign w_near   = (r_dot <= 0);
    assign w_far    = (r_dot >= r_len2);
    assign w_big    = |w_c[43:26];
    assign w_simple = !w_zero && (w_near ? (r_da2 <= w_h2s)
                                         : (w_far && (r_de2 <= w_h2s)));
    assign w_need   = !w_zero && !w_near && !w_far && !w_big;

    always_ff @(posedge i_clk) begin
        r_offx1 <= w_offx;
        r_offy1 <= w_offy;
        r_ax <= w_ax;  r_ay <= w_ay;  r_dx <= w_dx;  r_dy <= w_dy;
        r_ex <= (CW+3)'(w_ax) - (CW+3)'(w_dx);
        r_ey <= (CW+3)'(w_ay) - (CW+3)'(w_dy);
        r_pd1 <= r_ax * r_dx;  r_pd2 <= r_ay * r_dy;
        r_pl1 <= r_dx * r_dx;  r_pl2 <= r_dy * r_dy;
        r_pa1 <= r_ax * r_ax;  r_pa2 <= r_ay * r_ay;
        r_pe1 <= r_ex * r_ex;  r_pe2 <= r_ey * r_ey;
        r_pc1 <= r_ax * r_dy;  r_pc2 <= r_ay * r_dx;
        r_dot   <= 44'(r_pd1) + 44'(r_pd2);
        r_len2  <= 44'(r_pl1) + 44'(r_pl2);
        r_da2   <= 44'(r_pa1) + 44'(r_pa2);
        r_de2   <= 44'(r_pe1) + 44'(r_pe2);
        r_cross <= 44'(r_pc1) - 44'(r_pc2);
        r_simple <= w_simple;
        r_need   <= w_need;
        r_cc <= w_c26 * w_c26;
        r_hl <= r_h2 * w_len2u;
        r_color <= w_emit ? (r_hit ? i_cfg.line_color
                                   : (i_cfg.background_enabled ? i_cfg.background_color
                                                               : '0))
                          : r_color;
        r_cov <= w_emit ? r_hit : r_cov;
        r_eor <= w_emit ? r_last : r_eor;
        if (!i_rst_n) begin
            r_v1 <= 1'b0;  r_v2 <= 1'b0;  r_v3 <= 1'b0;  r_v4 <= 1'b0;  r_v5 <= 1'b0;
            r_hit <= 1'b0;
            r_ov  <= 1'b0;
        end else begin
            r_v1 <= (r_state == ST_RUN) && w_linked;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
            r_v5 <= r_v4;
            if (w_start) begin
                r_hit <= 1'b0;
            end else if (r_v5 && (r_simple || (r_need && (r_cc <= r_hl)))) begin
                r_hit <= 1'b1;
            end
            if (w_emit)            r_ov <= 1'b1;
            else if (o_out.ready)  r_ov <= 1'b0;
        end
    end

    assign o_out.valid         = r_ov;
    assign o_out.pixel_color   = r_color;
    assign o_out.covered       = r_cov;
    assign o_out.end_of_region = r_eor;

    a_idle_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> !w_busy)
        else $error("pipeline busy while idle");
    a_pair_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RUN) |-> (r_j < r_k) && (NW'(r_k) < r_n))
        else $error("pair index out of order or range");
    a_mod_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_MOD) |-> (r_n >= NW'(2)))
        else $error("ring step reduction with fewer than two points");
    a_emit_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_emit |=> (r_state == ST_IDLE) && r_ov)
        else $error("result not posted");
endmodule

>>> src/segment_mesh_pixel_coverage.sv
// segment_mesh_pixel_coverage: top level, configuration registers and the
// front/back split. Depends on smpc_pkg, smpc_ifs, smpc_front, smpc_back.
//
// Usage:
//  i_in carries items. action=load writes (coord_x, coord_y) into vertex
//  entry vertex_index; it gives no result. action=pixel tests the pixel
//  against every linked pair of the first point_count vertices, on 1 or 9
//  tile copies, and returns one item on o_out: pixel_color, covered and
//  the echoed end_of_region mark.
//  i_cfg writes one register per item (index 0..7 in list order); it is
//  always ready and must only be used while the block is idle.
//  For a pixel, the pair sequencer issues one vertex pair per cycle, for
//  each of the 9 tile copies when tiled or the single one otherwise, into
//  a test pipeline fed from the dual-read vertex RAM, then waits for it to
//  drain. Ring-step mode first reduces the step modulo the point count.
//  With twelve points and no tiling a pixel sweeps 66 vertex pairs.
//  A two-entry queue lets the input side keep accepting while the back end
//  works; a finished result sits in an output register, and a stalled
//  receiver only holds the back end once the next pixel is ready to post.
//  Reset (synchronous, active low) restores register defaults and empties
//  queue and pipeline; vertex entries stay undefined until loaded.
module segment_mesh_pixel_coverage
    import smpc_pkg::*;
#(
    parameter int MAX_POINTS = MAX_POINTS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    smpc_in_if.sink     i_in,
    smpc_cfg_if.sink    i_cfg,
    smpc_out_if.source  o_out
);
    t_cfg  r_cfg;
    t_item w_item;
    logic  w_item_valid;
    logic  w_item_ready;

    assign i_cfg.ready = 1'b1;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.point_count        <= RST_POINT_COUNT;
            r_cfg.link_mode          <= RST_LINK_MODE;
            r_cfg.link_step          <= RST_LINK_STEP;
            r_cfg.half_width         <= RST_HALF_THICK;
            r_cfg.tile_pitch         <= RST_TILE_PITCH;
            r_cfg.line_color         <= RST_LINE_COLOR;
            r_cfg.background_color   <= RST_BG_COLOR;
            r_cfg.background_enabled <= RST_BG_ENABLED;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                CFG_POINT_COUNT: r_cfg.point_count        <= i_cfg.data[6:0];
                CFG_LINK_MODE:   r_cfg.link_mode          <= i_cfg.data[2:0];
                CFG_LINK_STEP:   r_cfg.link_step          <= i_cfg.data[5:0];
                CFG_HALF_THICK:  r_cfg.half_width         <= i_cfg.data[6:0];
                CFG_TILE_PITCH:  r_cfg.tile_pitch         <= i_cfg.data[16:0];
                CFG_LINE_COLOR:  r_cfg.line_color         <= i_cfg.data;
                CFG_BG_COLOR:    r_cfg.background_color   <= i_cfg.data;
                CFG_BG_ENABLED:  r_cfg.background_enabled <= i_cfg.data[0];
                default:         r_cfg.point_count        <= r_cfg.point_count;
            endcase
        end
    end

    // front: accept and queue
    smpc_front #(
        .MAX_POINTS (MAX_POINTS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (i_in),
        .o_item       (w_item),
        .o_item_valid (w_item_valid),
        .i_item_ready (w_item_ready)
    );

    // back: vertex table, pair sweep, segment test, result register
    smpc_back #(
        .MAX_POINTS (MAX_POINTS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item       (w_item),
        .i_item_valid (w_item_valid),
        .o_item_ready (w_item_ready),
        .i_cfg        (r_cfg),
        .o_out        (o_out)
    );
endmodule

>>> verif/smpc_checker.sv
// smpc_checker: watches the input, output and configuration channels of the
// segment mesh pixel coverage block, predicts each pixel result and compares.
// Depends on smpc_pkg and smpc_ifs.
module smpc_checker
    import smpc_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    smpc_in_if   in_ch,
    smpc_out_if  out_ch,
    smpc_cfg_if  cfg_ch,
    output int   o_errors,
    output int   o_pending
);

    typedef struct packed {
        logic [COLW-1:0] pixel_color;
        logic            covered;
        logic            end_of_region;
    } t_result;

    t_cfg                 regs;
    logic signed [CW-1:0] vert_x [MAX_POINTS_DEF];
    logic signed [CW-1:0] vert_y [MAX_POINTS_DEF];
    t_result              expected_pixels [$];

    assign o_pending = expected_pixels.size();

    task automatic report(input string msg);
        $display("smpc_checker: mismatch at %0t: %s", $realtime, msg);
        o_errors++;
    endtask

    function automatic bit pair_linked(int j, int k, int n);
        int d, q, s;
        d = k - j;
        case (regs.link_mode)
            LINK_ALL:     return 1'b1;
            LINK_EVEN:    return (d % 2) == 0;
            LINK_THIRD:   return (d % 3) == 0;
            LINK_QUARTER: begin
                q = n / 4;
                if (q == 0) q = 1;
                return (d % q) == 0;
            end
            LINK_RING: begin
                s = int'(regs.link_step) % n;
                if (s == 0) return 1'b0;
                return d == s || d == n - s;
            end
            default:      return 1'b0;
        endcase
    endfunction

    // distance test on squared values; a zero-length segment never hits
    function automatic bit seg_hits(longint ax, longint ay, longint dx, longint dy,
                                    longint h2);
        longint len2, dot, ex, ey, c;
        len2 = dx * dx + dy * dy;
        if (len2 == 0) return 1'b0;
        dot = ax * dx + ay * dy;
        if (dot <= 0) return ax * ax + ay * ay <= h2;
        if (dot >= len2) begin
            ex = ax - dx;
            ey = ay - dy;
            return ex * ex + ey * ey <= h2;
        end
        c = ax * dy - ay * dx;
        if (c < 0) c = -c;
        if (c >= (64'sd1 <<< 26)) return 1'b0;
        return c * c <= h2 * len2;
    endfunction

    function automatic bit pixel_covered(longint px, longint py);
        int     n, lo;
        longint t, h2;
        n  = (regs.point_count > MAX_POINTS_DEF) ? MAX_POINTS_DEF : int'(regs.point_count);
        t  = longint'(regs.tile_pitch);
        lo = (regs.tile_pitch != 0) ? -1 : 0;
        h2 = longint'(regs.half_width) * longint'(regs.half_width);
        for (int tx = lo; tx <= -lo; tx++)
            for (int ty = lo; ty <= -lo; ty++)
                for (int j = 0; j < n; j++)
                    for (int k = j + 1; k < n; k++) begin
                        if (!pair_linked(j, k, n)) continue;
                        if (seg_hits(px - (longint'(vert_x[j]) + tx * t),
                                     py - (longint'(vert_y[j]) + ty * t),
                                     longint'(vert_x[k]) - longint'(vert_x[j]),
                                     longint'(vert_y[k]) - longint'(vert_y[j]), h2))
                            return 1'b1;
                    end
        return 1'b0;
    endfunction

    initial o_errors = 0;

    always @(posedge i_clk) begin
        t_result exp_r;
        if (!i_rst_n) begin
            regs.point_count        <= RST_POINT_COUNT;
            regs.link_mode          <= RST_LINK_MODE;
            regs.link_step          <= RST_LINK_STEP;
            regs.half_width         <= RST_HALF_THICK;
            regs.tile_pitch         <= RST_TILE_PITCH;
            regs.line_color         <= RST_LINE_COLOR;
            regs.background_color   <= RST_BG_COLOR;
            regs.background_enabled <= RST_BG_ENABLED;
            expected_pixels.delete();
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                if (expected_pixels.size() == 0) begin
                    report("result with nothing expected");
                end else begin
                    exp_r = expected_pixels.pop_front();
                    if (out_ch.pixel_color !== exp_r.pixel_color)
                        report($sformatf("pixel_color %h, expected %h",
                                         out_ch.pixel_color, exp_r.pixel_color));
                    if (out_ch.covered !== exp_r.covered)
                        report($sformatf("covered %b, expected %b",
                                         out_ch.covered, exp_r.covered));
                    if (out_ch.end_of_region !== exp_r.end_of_region)
                        report($sformatf("end_of_region %b, expected %b",
                                         out_ch.end_of_region, exp_r.end_of_region));
                end
            end
            if (in_ch.valid && in_ch.ready) begin
                if (in_ch.action == ACT_LOAD) begin
                    vert_x[in_ch.vertex_index] = in_ch.coord_x;
                    vert_y[in_ch.vertex_index] = in_ch.coord_y;
                end else begin
                    exp_r.covered = pixel_covered(longint'(in_ch.coord_x),
                                                  longint'(in_ch.coord_y));
                    exp_r.pixel_color = exp_r.covered ? regs.line_color :
                        (regs.background_enabled ? regs.background_color : '0);
                    exp_r.end_of_region = in_ch.last_in_region;
                    expected_pixels.push_back(exp_r);
                end
            end
            if (cfg_ch.valid && cfg_ch.ready) begin
                case (cfg_ch.index)
                    CFG_POINT_COUNT: regs.point_count        <= cfg_ch.data[6:0];
                    CFG_LINK_MODE:   regs.link_mode          <= cfg_ch.data[2:0];
                    CFG_LINK_STEP:   regs.link_step          <= cfg_ch.data[5:0];
                    CFG_HALF_THICK:  regs.half_width         <= cfg_ch.data[6:0];
                    CFG_TILE_PITCH:  regs.tile_pitch         <= cfg_ch.data[16:0];
                    CFG_LINE_COLOR:  regs.line_color         <= cfg_ch.data;
                    CFG_BG_COLOR:    regs.background_color   <= cfg_ch.data;
                    CFG_BG_ENABLED:  regs.background_enabled <= cfg_ch.data[0];
                    default: ;
                endcase
            end
        end
    end

endmodule

>>> verif/tb.sv
// tb: stimulus and verdict for segment_mesh_pixel_coverage; smpc_checker does
// the prediction and comparison. Depends on smpc_pkg, smpc_ifs, the block.
module tb;
    import smpc_pkg::*;

    localparam int WATCHDOG_LIMIT = 150000; // idle cycles

    logic i_clk;
    logic i_rst_n;
    int   errors;
    int   pending;
    int   idle_cycles;
    bit   calm;            // phase with no idling on either side
    int   stall_left;

    // stimulus-side copy of the vertex layout, used to aim pixels and place new vertices
    int   lay_x [MAX_POINTS_DEF];
    int   lay_y [MAX_POINTS_DEF];
    int   cur_n;
    int   cur_ht;
    int   cur_tile;

    smpc_in_if  in_if ();
    smpc_out_if out_if ();
    smpc_cfg_if cfg_if ();

    segment_mesh_pixel_coverage u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if.sink),
        .i_cfg   (cfg_if.sink),
        .o_out   (out_if.source)
    );

    smpc_checker u_checker (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .in_ch     (in_if),
        .out_ch    (out_if),
        .cfg_ch    (cfg_if),
        .o_errors  (errors),
        .o_pending (pending)
    );

    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    // mostly short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        if (calm) return 0;
        r = $urandom_range(99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(3, 1);
        return $urandom_range(60, 10);
    endfunction

    // receiver: random stalls, none in calm phases
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
            stall_left   <= 0;
        end else if (stall_left > 0) begin
            out_if.ready <= 1'b0;
            stall_left   <= stall_left - 1;
        end else begin
            out_if.ready <= 1'b1;
            stall_left   <= pick_gap();
        end
    end

    // no item accepted anywhere for too long ends the run
    always @(posedge i_clk) begin
        if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
            (cfg_if.valid && cfg_if.ready) || !i_rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // one item on the input channel; valid stays high into a back-to-back item
    task automatic send_item(input logic act, input logic [5:0] idx, input int x,
                             input int y, input logic last);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_if.valid          <= 1'b1;
        in_if.action         <= act;
        in_if.vertex_index   <= idx;
        in_if.coord_x        <= x[CW-1:0];
        in_if.coord_y        <= y[CW-1:0];
        in_if.last_in_region <= last;
        do @(posedge i_clk); while (!in_if.ready);
    endtask

    task automatic load_vertex(input int idx, input int x, input int y);
        send_item(ACT_LOAD, idx[5:0], x, y, 1'($urandom_range(1)));
        lay_x[idx] = x;
        lay_y[idx] = y;
    endtask

    // wait for all results, then let queued loads retire
    task automatic settle();
        in_if.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    // writes every register in one burst, valid held high throughout
    task automatic write_regs(input t_cfg c);
        logic [31:0] vals [8];
        vals[CFG_POINT_COUNT] = 32'(c.point_count);
        vals[CFG_LINK_MODE]   = 32'(c.link_mode);
        vals[CFG_LINK_STEP]   = 32'(c.link_step);
        vals[CFG_HALF_THICK]  = 32'(c.half_width);
        vals[CFG_TILE_PITCH]  = 32'(c.tile_pitch);
        vals[CFG_LINE_COLOR]  = c.line_color;
        vals[CFG_BG_COLOR]    = c.background_color;
        vals[CFG_BG_ENABLED]  = 32'(c.background_enabled);
        for (int i = 0; i < 8; i++) begin
            cfg_if.valid <= 1'b1;
            cfg_if.index <= i[2:0];
            cfg_if.data  <= vals[i];
            do @(posedge i_clk); while (!cfg_if.ready);
        end
        cfg_if.valid <= 1'b0;
        cur_n    = (c.point_count > MAX_POINTS_DEF) ? MAX_POINTS_DEF : int'(c.point_count);
        cur_ht   = int'(c.half_width);
        cur_tile = int'(c.tile_pitch);
    endtask

    // lays out the first count vertices scattered around a random centre so that
    // pixels can be aimed at segments
    task automatic new_layout(input int scale, input int count);
        int cx, cy;
        cx = $urandom_range(4000) - 2000;
        cy = $urandom_range(4000) - 2000;
        for (int i = 0; i < count; i++) begin
            if (i > 0 && $urandom_range(15) == 0)
                load_vertex(i, lay_x[i-1], lay_y[i-1]); // zero-length pair
            else
                load_vertex(i, cx + $urandom_range(2 * scale) - scale,
                            cy + $urandom_range(2 * scale) - scale);
        end
    endtask

    // pixel near a segment between two active vertices, or noise
    task automatic random_pixel();
        int j, k, f, x, y, m, r;
        r = $urandom_range(99);
        if (r < 8) begin
            x = $urandom_range(262143) - 131072;
            y = $urandom_range(262143) - 131072;
        end else begin
            m = (cur_n < 2) ? 2 : cur_n;
            j = $urandom_range(m - 1);
            k = $urandom_range(m - 1);
            f = $urandom_range(16);
            x = lay_x[j] + (lay_x[k] - lay_x[j]) * f / 16;
            y = lay_y[j] + (lay_y[k] - lay_y[j]) * f / 16;
            x += $urandom_range(4 * cur_ht + 2) - 2 * cur_ht - 1;
            y += $urandom_range(4 * cur_ht + 2) - 2 * cur_ht - 1;
            if (cur_tile != 0 && r < 40) begin
                x += ($urandom_range(2) - 1) * cur_tile;
                y += ($urandom_range(2) - 1) * cur_tile;
            end
        end
        send_item(ACT_PIXEL, 6'($urandom_range(63)), x, y, 1'($urandom_range(1)));
    endtask

    task automatic random_items(input int count);
        int r;
        for (int i = 0; i < count; i++) begin
            r = $urandom_range(99);
            if (r < 70)
                random_pixel();
            else if (r < 73)
                load_vertex($urandom_range(63), $urandom_range(262143) - 131072,
                            $urandom_range(262143) - 131072);
            else
                load_vertex($urandom_range(63), lay_x[$urandom_range(63)] +
                            $urandom_range(600) - 300,
                            lay_y[$urandom_range(63)] + $urandom_range(600) - 300);
        end
    endtask

    task automatic run_phase(input int pc, input int mode, input int step, input int ht,
                             input int tile, input int count);
        t_cfg c;
        settle();
        c.point_count        = pc[6:0];
        c.link_mode          = mode[2:0];
        c.link_step          = step[5:0];
        c.half_width         = ht[6:0];
        c.tile_pitch         = tile[16:0];
        c.line_color         = $urandom();
        c.background_color   = $urandom();
        c.background_enabled = 1'($urandom_range(1));
        write_regs(c);
        calm = ($urandom_range(3) == 0);
        new_layout($urandom_range(3000, 100), cur_n);
        random_items(count);
    endtask

    initial begin
        t_cfg c;
        calm                 = 1'b0;
        cur_n                = int'(RST_POINT_COUNT);
        cur_ht               = int'(RST_HALF_THICK);
        cur_tile             = int'(RST_TILE_PITCH);
        i_rst_n              <= 1'b0;
        in_if.valid          <= 1'b0;
        in_if.action         <= ACT_LOAD;
        in_if.vertex_index   <= '0;
        in_if.coord_x        <= '0;
        in_if.coord_y        <= '0;
        in_if.last_in_region <= 1'b0;
        cfg_if.valid         <= 1'b0;
        cfg_if.index         <= CFG_POINT_COUNT;
        cfg_if.data          <= '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings: fill the whole table first so no entry is unwritten
        new_layout(800, MAX_POINTS_DEF);
        // directed: pixel on a vertex, the coordinate extremes, both marks
        send_item(ACT_PIXEL, 6'd0, lay_x[0], lay_y[0], 1'b1);
        send_item(ACT_PIXEL, 6'd63, -131072, -131072, 1'b0);
        send_item(ACT_PIXEL, 6'd0, 131071, 131071, 1'b1);
        send_item(ACT_PIXEL, 6'd0, -131072, 131071, 1'b0);
        // a segment reaching the coordinate extremes
        load_vertex(2, 131071, -131072);
        load_vertex(3, -131072, 131071);
        send_item(ACT_PIXEL, 6'd0, 0, 0, 1'b1);
        send_item(ACT_PIXEL, 6'd0, 131071, -131072, 1'b0);
        // zero-length pair: vertex 1 on top of vertex 0, alone nearby
        load_vertex(1, lay_x[0], lay_y[0]);
        send_item(ACT_PIXEL, 6'd0, lay_x[0] + 10, lay_y[0], 1'b1);
        // endpoint and interior distances just at and past the half width
        load_vertex(4, 0, 0);
        load_vertex(5, 1600, 0);
        send_item(ACT_PIXEL, 6'd0, 800, 40, 1'b0);
        send_item(ACT_PIXEL, 6'd0, 800, 41, 1'b1);
        send_item(ACT_PIXEL, 6'd0, -40, 0, 1'b0);
        send_item(ACT_PIXEL, 6'd0, 1641, 0, 1'b1);
        send_item(ACT_PIXEL, 6'd0, 1628, 28, 1'b0);
        random_items(60);

        // pc, mode, step, half width, tile, items
        run_phase(3,   LINK_ALL,     1,  4,   0,      100);
        run_phase(12,  LINK_EVEN,    5,  80,  0,      100);
        run_phase(12,  LINK_THIRD,   1,  40,  1600,   90);
        run_phase(16,  LINK_QUARTER, 1,  127, 0,      100);
        run_phase(5,   LINK_QUARTER, 0,  20,  0,      90);   // quarter count one
        run_phase(2,   LINK_ALL,     1,  60,  0,      50);   // a single pair
        run_phase(1,   LINK_ALL,     1,  60,  0,      30);   // no pairs at all
        run_phase(0,   LINK_RING,    7,  60,  0,      30);
        run_phase(10,  LINK_RING,    3,  50,  0,      90);
        run_phase(10,  LINK_RING,    10, 50,  0,      50);   // step wraps to zero
        run_phase(7,   LINK_RING,    63, 30,  2400,   70);
        run_phase(8,   5,            1,  40,  0,      30);   // undefined link modes
        run_phase(8,   7,            1,  40,  0,      20);
        run_phase(64,  LINK_ALL,     1,  40,  0,      25);
        run_phase(127, LINK_RING,    33, 0,   0,      25);   // count saturates
        run_phase(12,  LINK_ALL,     32, 80,  131071, 70);
        run_phase(9,   LINK_THIRD,   1,  60,  800,    80);
        run_phase(6,   LINK_EVEN,    1,  10,  1,      80);

        // last phase back at the reset values with extreme colors
        settle();
        c.point_count        = RST_POINT_COUNT;
        c.link_mode          = RST_LINK_MODE;
        c.link_step          = RST_LINK_STEP;
        c.half_width         = RST_HALF_THICK;
        c.tile_pitch         = RST_TILE_PITCH;
        c.line_color         = '0;
        c.background_color   = '1;
        c.background_enabled = 1'b1;
        write_regs(c);
        calm = 1'b0;
        random_items(60);

        settle();
        repeat (100) @(posedge i_clk);
        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

>>> sim.f
src/smpc_pkg.sv
src/smpc_ifs.sv
src/smpc_ram.sv
src/smpc_front.sv
src/smpc_back.sv
src/segment_mesh_pixel_coverage.sv
verif/smpc_checker.sv
verif/tb.sv
